>>> rtl/ptts_pkg.sv
// ptts_pkg: shared types, constants and helper functions for the periodic task table scheduler
// no dependencies; imported by ptts_seq, ptts_outreg and the top level
package ptts_pkg;

  localparam int TASK_SLOTS  = 8;
  localparam int MAX_RESULTS = 8;

  // slot index width, counter width (holds TASK_SLOTS), result counter width
  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int NW = $clog2(MAX_RESULTS + 1);

  localparam logic [6:0] SLOTS_W   = 7'(TASK_SLOTS);
  localparam logic [3:0] SLOT_NONE = SLOTS_W[3:0];

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_DEL  = 2'd2,
    OP_DISP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  // one table entry as kept in the slot memory
  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] countdown;
    logic [15:0] period;
  } entry_t;

  // one result word toward the output register
  typedef struct packed {
    logic [3:0]  slot;
    logic [15:0] tag;
    status_t     status;
    logic        is_last;
  } res_t;

  function automatic logic [IW-1:0] lowest_set(input logic [TASK_SLOTS-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = IW'(i);
    end
    return r;
  endfunction

  // slot numbers are masked to the 4-bit result field
  function automatic logic [3:0] to_slot(input logic [IW-1:0] i);
    logic [IW+3:0] w;
    w = {4'b0000, i};
    return w[3:0];
  endfunction

endpackage

>>> rtl/ptts_ram.sv
// ptts_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
module ptts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ptts_seq.sv
// ptts_seq: sequencer that runs tick, add, delete and dispatch over the slot memory
// depends on ptts_pkg; drives ptts_ram and the output register
module ptts_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  ptts_pkg::op_t          operation,
  input  logic [15:0]            task_tag,
  input  logic [15:0]            first_delay,
  input  logic [15:0]            repeat_period,
  input  logic [5:0]             slot_index,
  output logic [ptts_pkg::IW-1:0] raddr,
  input  ptts_pkg::entry_t       rdata,
  output logic                   we,
  output logic [ptts_pkg::IW-1:0] waddr,
  output ptts_pkg::entry_t       wdata,
  output ptts_pkg::res_t         res,
  output logic                   res_load,
  input  logic                   res_ready
);
  import ptts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_ADD,
    S_DEL,
    S_FIND,
    S_EMIT
  } state_t;

  state_t               state;
  logic [CW-1:0]        rd_cnt;
  logic                 pv;
  logic [IW-1:0]        pidx;
  logic [IW-1:0]        sel;
  logic [NW-1:0]        n_cnt;
  logic [TASK_SLOTS-1:0] valid;
  logic [TASK_SLOTS-1:0] due;
  entry_t               item;
  logic [5:0]           idx_r;

  logic [TASK_SLOTS-1:0] pending;
  logic [TASK_SLOTS-1:0] free;
  logic [TASK_SLOTS-1:0] sel_bit;
  logic [TASK_SLOTS-1:0] rest;
  logic                 idx_ok;
  logic                 last_disp;
  logic                 scan_done;
  logic [IW-1:0]        free_idx;
  logic [IW-1:0]        pend_idx;

  assign pending   = due & valid;
  assign free      = ~valid;
  assign free_idx  = lowest_set(free);
  assign pend_idx  = lowest_set(pending);
  assign idx_ok    = {1'b0, idx_r} < SLOTS_W;
  assign scan_done = rd_cnt == CW'(TASK_SLOTS);
  assign req_stall = state != S_IDLE;

  always_comb begin
    sel_bit      = '0;
    sel_bit[sel] = 1'b1;
  end

  assign rest      = pending & ~sel_bit;
  assign last_disp = (rest == '0) || (n_cnt == NW'(MAX_RESULTS - 1));

  // read address: scan counter on tick, search result while looking, held slot on emit
  always_comb begin
    case (state)
      S_TICK:  raddr = rd_cnt[IW-1:0];
      S_FIND:  raddr = pend_idx;
      default: raddr = sel;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = pidx;
    wdata = rdata;
    case (state)
      S_TICK: begin
        we = pv && valid[pidx];
        if (rdata.countdown == 16'd0) wdata.countdown = rdata.period;
        else wdata.countdown = rdata.countdown - 16'd1;
      end
      S_ADD: begin
        we    = res_ready && (free != '0);
        waddr = free_idx;
        wdata = item;
      end
      default: ;
    endcase
  end

  always_comb begin
    res      = '{slot: SLOT_NONE, tag: 16'd0, status: ST_OK, is_last: 1'b1};
    res_load = 1'b0;
    case (state)
      S_ADD: begin
        res_load = res_ready;
        if (free != '0) res.slot = to_slot(free_idx);
        else res.status = ST_FULL;
      end
      S_DEL: begin
        res_load = res_ready;
        if (!idx_ok) res.status = ST_BADIDX;
        else if (!valid[idx_r[IW-1:0]]) res.status = ST_EMPTY;
      end
      S_FIND: begin
        // nothing due: a single empty word
        res_load = res_ready && (pending == '0);
      end
      S_EMIT: begin
        res_load    = res_ready;
        res.slot    = to_slot(sel);
        res.tag     = rdata.tag;
        res.is_last = last_disp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_cnt <= '0;
      pv     <= 1'b0;
      n_cnt  <= '0;
      valid  <= '0;
      due    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item   <= '{tag: task_tag, countdown: first_delay, period: repeat_period};
            idx_r  <= slot_index;
            rd_cnt <= '0;
            pv     <= 1'b0;
            n_cnt  <= '0;
            case (operation)
              OP_TICK: state <= S_TICK;
              OP_ADD:  state <= S_ADD;
              OP_DEL:  state <= S_DEL;
              default: state <= S_FIND;
            endcase
          end
        end
        S_TICK: begin
          // read of slot k overlaps write-back of slot k-1
          if (!scan_done) begin
            pidx   <= rd_cnt[IW-1:0];
            pv     <= 1'b1;
            rd_cnt <= rd_cnt + 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (pv && valid[pidx] && (rdata.countdown == 16'd0)) due[pidx] <= 1'b1;
          if (pv && scan_done) state <= S_IDLE;
        end
        S_ADD: begin
          if (res_ready) begin
            if (free != '0) begin
              valid[free_idx] <= 1'b1;
              due[free_idx]   <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        S_DEL: begin
          if (res_ready) begin
            if (idx_ok) begin
              valid[idx_r[IW-1:0]] <= 1'b0;
              due[idx_r[IW-1:0]]   <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        S_FIND: begin
          if (pending != '0) begin
            sel   <= pend_idx;
            state <= S_EMIT;
          end else if (res_ready) begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            due[sel] <= 1'b0;
            if (rdata.period == 16'd0) valid[sel] <= 1'b0;
            n_cnt <= n_cnt + 1'b1;
            state <= last_disp ? S_IDLE : S_FIND;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_due_valid: assert property (@(posedge clk) disable iff (rst)
    (due & ~valid) == '0)
    else $error("due flag set on a free slot");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_TICK || state == S_ADD))
    else $error("memory write outside tick or add");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_load |-> res_ready)
    else $error("result word loaded into a full output register");

  a_sel_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && $past(state == S_EMIT)) |-> $stable(sel))
    else $error("dispatch slot changed while its word waits");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_TICK |-> rd_cnt <= CW'(TASK_SLOTS))
    else $error("tick scan ran past the table");

endmodule

>>> rtl/ptts_outreg.sv
// ptts_outreg: output register that holds one result word until the receiver takes it
// depends on ptts_pkg
module ptts_outreg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  ptts_pkg::res_t res,
  output logic           ready,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output logic [3:0]     slot,
  output logic [15:0]    tag_out,
  output logic [1:0]     status,
  output logic           is_last
);
  import ptts_pkg::*;

  res_t hold;

  assign ready   = !rsp_valid || !rsp_stall;
  assign slot    = hold.slot;
  assign tag_out = hold.tag;
  assign status  = hold.status;
  assign is_last = hold.is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (load) hold <= res;
  end

endmodule

>>> rtl/periodic_task_table_scheduler.sv
// periodic_task_table_scheduler: top level of the task table scheduler
// depends on ptts_pkg, ptts_ram, ptts_seq and ptts_outreg
//
// request channel (req_valid / req_stall) carries one command word: tick, add
// task, delete task or dispatch due tasks. response channel (rsp_valid /
// rsp_stall) carries result words; is_last marks the final word of a command.
// tick gives no word; add and delete give one; dispatch gives one word per due
// slot in slot order, or a single empty word when nothing is due.
// one command is in work at a time; req_stall is high until it is done.
// how each command proceeds:
//   tick      one slot per cycle through the slot memory read port, the
//             write-back of a slot overlapping the next read
//   add, del  table update and result word load together
//   dispatch  memory read, then emit, for each due slot in turn
// each result word appears the cycle after the sequencer loads it.
// when the receiver stalls, the word waits in the output register and the
// sequencer holds until it can load the next one; nothing is dropped.
// synchronous reset frees every slot at once; no clearing pass is needed.
module periodic_task_table_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] task_tag,
  input  logic [15:0] first_delay,
  input  logic [15:0] repeat_period,
  input  logic [5:0]  slot_index,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [3:0]  slot,
  output logic [15:0] tag_out,
  output logic [1:0]  status,
  output logic        is_last
);
  import ptts_pkg::*;

  logic [IW-1:0]         raddr;
  logic [IW-1:0]         waddr;
  logic                  we;
  entry_t                wdata;
  entry_t                rdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  res_t                  res;
  logic                  res_load;
  logic                  res_ready;

  assign rdata = entry_t'(ram_rdata);

  ptts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TASK_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  ptts_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .operation     (op_t'(operation)),
    .task_tag      (task_tag),
    .first_delay   (first_delay),
    .repeat_period (repeat_period),
    .slot_index    (slot_index),
    .raddr         (raddr),
    .rdata         (rdata),
    .we            (we),
    .waddr         (waddr),
    .wdata         (wdata),
    .res           (res),
    .res_load      (res_load),
    .res_ready     (res_ready)
  );

  ptts_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res       (res),
    .ready     (res_ready),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .slot      (slot),
    .tag_out   (tag_out),
    .status    (status),
    .is_last   (is_last)
  );

endmodule
